// ===== sv/swtq_pkg.sv =====
// shared types and constants for the sorted wakeup timer queue
`default_nettype none
package swtq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int TICK_W          = 48;
  localparam int ID_W            = 16;
  localparam int OCC_W           = 7;

  typedef enum logic {
    FUNC_ENQ  = 1'b0,
    FUNC_TICK = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_WOKEN    = 2'd2,
    ST_NONE_DUE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_WAKE,
    S_FLUSH
  } state_t;

  typedef struct packed {
    func_t             func;
    logic [ID_W-1:0]   task_id;
    logic [TICK_W-1:0] wake_at;
    logic [TICK_W-1:0] now_tick;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  woken_id;
    logic             last;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic [ID_W-1:0]   task_id;
  } entry_t;

endpackage
`default_nettype wire

// ===== sv/swtq_mem.sv =====
// entry store: one write port, one read port with registered read data
`default_nettype none
module swtq_mem #(
  parameter int DEPTH = swtq_pkg::QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  swtq_pkg::entry_t     wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output swtq_pkg::entry_t     rdata
);
  import swtq_pkg::*;

  entry_t store_r [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= store_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== sv/swtq_ctrl.sv =====
// sequencer: circular buffer pointers, insertion walk, wake drain, output register
`default_nettype none
module swtq_ctrl #(
  parameter int DEPTH = swtq_pkg::QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  swtq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output swtq_pkg::out_item_t  out_data,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output swtq_pkg::entry_t     mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  swtq_pkg::entry_t     mem_rdata
);
  import swtq_pkg::*;

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W  = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [AW-1:0]     wphys_r, wphys_nxt;
  in_item_t          req_r, req_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;
  logic [CW-1:0]     pend_occ_r, pend_occ_nxt;
  logic              have_pend_r, have_pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              slot_free;
  logic              acc;
  logic              due;
  logic              shift;
  logic              wake_act;
  logic [AW:0]       tail_sum;
  logic [AW-1:0]     tail_phys;
  logic [AW-1:0]     wdec, wdec2, head_inc;
  entry_t            new_entry;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? LAST_IDX : p - AW'(1);
  endfunction

  function automatic out_item_t make_out(input status_t st, input logic [ID_W-1:0] id,
                                         input logic lst, input logic [CW-1:0] occ);
    out_item_t o;
    o.status    = st;
    o.woken_id  = id;
    o.last      = lst;
    o.occupancy = OCC_W'(occ);
    make_out    = o;
  endfunction

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && slot_free);
  assign acc       = in_valid && !in_stall;

  assign tail_sum  = {1'b0, head_r} + (AW+1)'(count_r);
  assign tail_phys = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);
  assign wdec      = ptr_dec(wphys_r);
  assign wdec2     = ptr_dec(wdec);
  assign head_inc  = ptr_inc(head_r);

  assign new_entry.tick    = req_r.wake_at;
  assign new_entry.task_id = req_r.task_id;

  // entry ahead of the slot moves up while its tick is strictly later
  assign shift    = mem_rdata.tick > req_r.wake_at;
  assign due      = mem_rdata.tick <= req_r.now_tick;
  // a drain step needs the output slot unless it only picks up the first due entry
  assign wake_act = (have_pend_r || !due) ? slot_free : 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_data.func == FUNC_ENQ) begin
            if (count_r != FULL_CNT && count_r != '0) begin
              state_nxt = S_INS;
            end
          end else if (count_r != '0) begin
            state_nxt = S_WAKE;
          end
        end
      end
      S_INS: begin
        if (shift) begin
          state_nxt = (pos_r == ONE_CNT) ? S_INS_PUT : S_INS;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_INS_PUT: state_nxt = S_IDLE;
      S_WAKE: begin
        if (wake_act) begin
          if (due) begin
            state_nxt = (count_r == ONE_CNT) ? S_FLUSH : S_WAKE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory requests and output register
  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    wphys_nxt     = wphys_r;
    req_nxt       = req_r;
    pend_id_nxt   = pend_id_r;
    pend_occ_nxt  = pend_occ_r;
    have_pend_nxt = have_pend_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = wphys_r;
    mem_wdata     = new_entry;
    mem_re        = 1'b0;
    mem_raddr     = head_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          req_nxt = in_data;
          if (in_data.func == FUNC_ENQ) begin
            if (count_r == FULL_CNT) begin
              out_item_nxt  = make_out(ST_REJECTED, '0, 1'b1, count_r);
              out_valid_nxt = 1'b1;
            end else if (count_r == '0) begin
              // empty queue: the item goes straight to the head slot
              mem_we            = 1'b1;
              mem_waddr         = head_r;
              mem_wdata.tick    = in_data.wake_at;
              mem_wdata.task_id = in_data.task_id;
              count_nxt         = count_r + ONE_CNT;
              out_item_nxt      = make_out(ST_ENQUEUED, '0, 1'b1, count_r + ONE_CNT);
              out_valid_nxt     = 1'b1;
            end else begin
              wphys_nxt = tail_phys;
              pos_nxt   = count_r;
              mem_re    = 1'b1;
              mem_raddr = ptr_dec(tail_phys);
            end
          end else begin
            if (count_r == '0) begin
              out_item_nxt  = make_out(ST_NONE_DUE, '0, 1'b1, count_r);
              out_valid_nxt = 1'b1;
            end else begin
              have_pend_nxt = 1'b0;
              mem_re        = 1'b1;
              mem_raddr     = head_r;
            end
          end
        end
      end
      S_INS: begin
        if (shift) begin
          mem_we    = 1'b1;
          mem_waddr = wphys_r;
          mem_wdata = mem_rdata;
          wphys_nxt = wdec;
          pos_nxt   = pos_r - ONE_CNT;
          if (pos_r != ONE_CNT) begin
            mem_re    = 1'b1;
            mem_raddr = wdec2;
          end
        end else begin
          mem_we        = 1'b1;
          mem_waddr     = wphys_r;
          count_nxt     = count_r + ONE_CNT;
          out_item_nxt  = make_out(ST_ENQUEUED, '0, 1'b1, count_r + ONE_CNT);
          out_valid_nxt = 1'b1;
        end
      end
      S_INS_PUT: begin
        mem_we        = 1'b1;
        mem_waddr     = wphys_r;
        count_nxt     = count_r + ONE_CNT;
        out_item_nxt  = make_out(ST_ENQUEUED, '0, 1'b1, count_r + ONE_CNT);
        out_valid_nxt = 1'b1;
      end
      S_WAKE: begin
        if (wake_act) begin
          if (have_pend_r) begin
            out_item_nxt  = make_out(ST_WOKEN, pend_id_r, !due, pend_occ_r);
            out_valid_nxt = 1'b1;
          end else if (!due) begin
            out_item_nxt  = make_out(ST_NONE_DUE, '0, 1'b1, count_r);
            out_valid_nxt = 1'b1;
          end
          if (due) begin
            pend_id_nxt   = mem_rdata.task_id;
            pend_occ_nxt  = count_r - ONE_CNT;
            have_pend_nxt = 1'b1;
            head_nxt      = head_inc;
            count_nxt     = count_r - ONE_CNT;
            if (count_r != ONE_CNT) begin
              mem_re    = 1'b1;
              mem_raddr = head_inc;
            end
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          out_item_nxt  = make_out(ST_WOKEN, pend_id_r, 1'b1, pend_occ_r);
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      have_pend_r <= have_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    wphys_r    <= wphys_nxt;
    req_r      <= req_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_occ_r <= pend_occ_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
`default_nettype wire

// ===== sv/sorted_wakeup_timer_queue_core.sv =====
// top level of the sorted wakeup timer queue
//
//   group | handshake             | payload
//   in_   | in_valid / in_stall   | in_data: func, task_id, wake_at, now_tick
//   out_  | out_valid / out_stall | out_data: status, woken_id, last, occupancy
//
// enqueue: an empty or full queue is answered straight from idle, else the walk moves each later-tick entry up
// tick item: an empty queue is answered straight from idle, else due entries drain, one pop a cycle while not stalled
// entries sit in a circular buffer in one memory, so a wakeup only moves the head pointer
// reset clears the head pointer and count; the store itself needs no clearing
// a stalled output holds the drain in place; a new item is taken only when idle
// and the output register is free or being emptied
`default_nettype none
module sorted_wakeup_timer_queue_core #(
  parameter int QUEUE_DEPTH = swtq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  swtq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output swtq_pkg::out_item_t  out_data
);
  import swtq_pkg::*;

  // physical slot index and a count that can hold the full depth
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  // sequencer with pointers and output register
  swtq_ctrl #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // tick and task store
  swtq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire
